[src/rmv_pkg.sv]
// Shared types, codes and constants of the running mean, variance and min/max block.
package rmv_pkg;

   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int COUNT_WIDTH_DEF  = 32;
   localparam int FIELD_WIDTH      = 32;
   localparam int SUM_WIDTH        = 64;
   localparam int STEP_WIDTH       = $clog2(SUM_WIDTH + 1);

   localparam int REQ_TDATA_WIDTH  = 32;
   localparam int REQ_TUSER_WIDTH  = 2;
   localparam int RSP_TDATA_WIDTH  = 232;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH   = 32;

   localparam logic signed [FIELD_WIDTH-1:0] MIN_START_RST = 32'sd100000000;
   localparam logic signed [FIELD_WIDTH-1:0] MAX_START_RST = -32'sd100000000;
   localparam logic [SUM_WIDTH-1:0] SUM_LIMIT = {1'b0, {(SUM_WIDTH-1){1'b1}}};

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_START = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_START = 1'b1;

   typedef enum logic [REQ_TUSER_WIDTH-1:0] {
      OP_INCLUDE = 2'd0,
      OP_STORE   = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep;
      logic clear;
      logic divm_start;
      logic mean_upd;
      logic mul;
      logic acc;
      logic divv_start;
      logic out_load;
   } rmv_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic op_include;
      logic op_clear;
   } rmv_status_type;

endpackage

[src/rmv_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module rmv_div
   import rmv_pkg::*;
#(
   parameter int DVD_W = SUM_WIDTH,
   parameter int DVS_W = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [STEP_WIDTH-1:0] steps,
   input  logic [DVD_W-1:0]      dividend,
   input  logic [DVS_W-1:0]      divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   logic [DVD_W-1:0]      quo_ff;
   logic [DVS_W-1:0]      rem_ff;
   logic [DVS_W-1:0]      dvs_ff;
   logic [STEP_WIDTH-1:0] cnt_ff;
   logic                  done_ff;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;
   logic [DVS_W-1:0] rem_in;

   assign trial  = {rem_ff, quo_ff[DVD_W-1]};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign diff   = trial - {1'b0, dvs_ff};
   // When the divisor does not fit, the trial value is below the divisor and so fits DVS_W bits.
   assign rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == STEP_WIDTH'(1));
         if (start) begin
            cnt_ff <= steps;
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - STEP_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/rmv_dp.sv]
// Datapath: statistics registers, mean and variance division, product and saturating sum.
module rmv_dp
   import rmv_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rmv_cmd_type                cmd,
   output rmv_status_type             status,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int PAD_WIDTH = RSP_TDATA_WIDTH - (5 * FIELD_WIDTH + SUM_WIDTH + 2);

   // Item held while it is worked on.
   op_type                 op_ff;
   logic signed [SW-1:0]   x_ff;

   // Statistics state.
   logic signed [SW-1:0]          mean_ff;
   logic [SUM_WIDTH-1:0]          dev_sum_ff;
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic signed [FIELD_WIDTH-1:0] min_ff;
   logic signed [FIELD_WIDTH-1:0] max_ff;
   logic                          new_max_ff;
   logic                          new_min_ff;
   logic signed [SW-1:0]          kept_ff;
   logic signed [FIELD_WIDTH-1:0] min_start_ff;
   logic signed [FIELD_WIDTH-1:0] max_start_ff;

   // Intermediate values.
   logic [SW:0]                d1_ff;
   logic [2*SW-1:0]            prod_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_ff;

   logic [SW:0]                   d1_in;
   logic [SW:0]                   d1_neg;
   logic [SW-1:0]                 d1_mag;
   logic [SW:0]                   d2;
   logic [SW:0]                   d2_neg;
   logic [SW-1:0]                 d2_mag;
   logic [2*SW-1:0]               prod_in;
   logic [SW:0]                   mean_ext;
   logic [SW:0]                   q_ext;
   logic [SW:0]                   mean_sum;
   logic [SUM_WIDTH:0]            total;
   logic signed [FIELD_WIDTH-1:0] x_wide;
   logic                          above_max;
   logic                          below_min;
   logic                          div_start;
   logic [STEP_WIDTH-1:0]         div_steps;
   logic [SUM_WIDTH-1:0]          div_dividend;
   logic [COUNT_WIDTH-1:0]        div_divisor;
   logic                          div_done;
   logic [SUM_WIDTH-1:0]          div_quotient;

   assign status.div_done   = div_done;
   assign status.op_include = (op_ff == OP_INCLUDE) || (op_ff == OP_STORE);
   assign status.op_clear   = (op_ff == OP_CLEAR);

   assign d1_in  = {x_ff[SW-1], x_ff} - {mean_ff[SW-1], mean_ff};
   assign d1_neg = -d1_ff;
   // The distance between two SW-bit values stays below 2^SW, so SW bits hold its magnitude.
   assign d1_mag = d1_ff[SW] ? d1_neg[SW-1:0] : d1_ff[SW-1:0];

   assign d2      = {x_ff[SW-1], x_ff} - {mean_ff[SW-1], mean_ff};
   assign d2_neg  = -d2;
   assign d2_mag  = d2[SW] ? d2_neg[SW-1:0] : d2[SW-1:0];
   assign prod_in = {{SW{1'b0}}, d2_mag} * {{SW{1'b0}}, d1_mag};

   // The mean moves toward the sample by the truncated quotient, so it stays in SW bits.
   assign mean_ext = {mean_ff[SW-1], mean_ff};
   assign q_ext    = {1'b0, div_quotient[SW-1:0]};
   assign mean_sum = d1_ff[SW] ? (mean_ext - q_ext) : (mean_ext + q_ext);

   assign total = {1'b0, dev_sum_ff} + (SUM_WIDTH + 1)'(prod_ff);

   assign x_wide    = FIELD_WIDTH'(x_ff);
   assign above_max = x_wide > max_ff;
   assign below_min = x_wide < min_ff;

   assign div_start    = cmd.divm_start || cmd.divv_start;
   assign div_steps    = cmd.divm_start ? STEP_WIDTH'(SW) : STEP_WIDTH'(SUM_WIDTH);
   assign div_dividend = cmd.divm_start ? {d1_mag, {(SUM_WIDTH - SW){1'b0}}} : dev_sum_ff;
   assign div_divisor  = (cmd.divm_start || (count_ff != '0)) ? count_ff
                                                              : COUNT_WIDTH'(1);

   rmv_div #(
      .DVD_W (SUM_WIDTH),
      .DVS_W (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff      <= '0;
         dev_sum_ff   <= '0;
         count_ff     <= '0;
         min_ff       <= MIN_START_RST;
         max_ff       <= MAX_START_RST;
         new_max_ff   <= 1'b0;
         new_min_ff   <= 1'b0;
         kept_ff      <= '0;
         min_start_ff <= MIN_START_RST;
         max_start_ff <= MAX_START_RST;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_MIN_START: min_start_ff <= csr_wdata;
               CSR_MAX_START: max_start_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.prep) begin
            if (count_ff != '1) begin
               count_ff <= count_ff + COUNT_WIDTH'(1);
            end
            if (op_ff == OP_STORE) begin
               kept_ff <= x_ff;
            end
         end
         if (cmd.clear) begin
            count_ff   <= '0;
            dev_sum_ff <= '0;
            min_ff     <= min_start_ff;
            max_ff     <= max_start_ff;
         end
         if (cmd.mean_upd) begin
            mean_ff <= mean_sum[SW-1:0];
         end
         if (cmd.acc) begin
            dev_sum_ff <= (total > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : total[SUM_WIDTH-1:0];
            new_max_ff <= above_max;
            new_min_ff <= below_min;
            if (above_max) begin
               max_ff <= x_wide;
            end
            if (below_min) begin
               min_ff <= x_wide;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op_type'(req_tuser);
         x_ff  <= req_tdata[SW-1:0];
      end
      if (cmd.prep) begin
         d1_ff <= d1_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         rsp_ff <= {{PAD_WIDTH{1'b0}},
                    FIELD_WIDTH'(kept_ff),
                    new_min_ff,
                    new_max_ff,
                    FIELD_WIDTH'(count_ff),
                    min_ff,
                    max_ff,
                    div_quotient,
                    FIELD_WIDTH'(mean_ff)};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

[src/rmv_ctrl.sv]
// Controller: sequences one item through the datapath and runs both handshakes.
module rmv_ctrl
   import rmv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  rmv_status_type status,
   output rmv_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DIVM_GO,
      S_DIVM_WAIT,
      S_MEAN,
      S_MUL,
      S_ACC,
      S_DIVV_GO,
      S_DIVV_WAIT,
      S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // The result register can take a new result once the old one is gone or leaving.
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_valid_in = ((state_ff == S_OUT) && out_free) || (rsp_valid_ff && !rsp_tready);

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:      cmd.load       = req_tvalid;
         S_DECODE: begin
            cmd.prep  = status.op_include;
            cmd.clear = status.op_clear;
         end
         S_DIVM_GO:   cmd.divm_start = 1'b1;
         S_DIVM_WAIT: ;
         S_MEAN:      cmd.mean_upd   = 1'b1;
         S_MUL:       cmd.mul        = 1'b1;
         S_ACC:       cmd.acc        = 1'b1;
         S_DIVV_GO:   cmd.divv_start = 1'b1;
         S_DIVV_WAIT: ;
         S_OUT:       cmd.out_load   = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE:    state_ff <= status.op_include ? S_DIVM_GO : S_DIVV_GO;
            S_DIVM_GO:   state_ff <= S_DIVM_WAIT;
            S_DIVM_WAIT: begin
               if (status.div_done) begin
                  state_ff <= S_MEAN;
               end
            end
            S_MEAN:      state_ff <= S_MUL;
            S_MUL:       state_ff <= S_ACC;
            S_ACC:       state_ff <= S_DIVV_GO;
            S_DIVV_GO:   state_ff <= S_DIVV_WAIT;
            S_DIVV_WAIT: begin
               if (status.div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:     state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[src/running_mean_variance_minmax.sv]
// Top level of the running mean, variance and min/max block.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_tvalid/tready  | tuser: cmd; tdata: sample
//   rsp     | out       | rsp_tvalid/tready  | tdata: mean, variance, max, min, count,
//           |           |                    |        new-max flag, new-min flag, kept sample
//   csr     | in        | csr_wen            | csr_index, csr_wdata
//
// An include or store item passes twice through the shared serial divider: SAMPLE_WIDTH
// steps for the mean, then 64 steps for the variance. A clear or unused command makes only
// the variance pass. One item is worked on at a time; the next item can be accepted once
// the previous result is in the output register, so a stalled result blocks only the
// finish of the following item. Reset is synchronous and restores all statistics and both
// start registers.
module running_mean_variance_minmax
   import rmv_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // cmd [1:0]
   input  logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   // sample [31:0]
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // mean_value [31:0], variance [95:32], max_value [127:96], min_value [159:128],
   // sample_count [191:160], is_new_max [192], is_new_min [193], kept_sample [225:194],
   // zero [231:226]
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   rmv_cmd_type    cmd;
   rmv_status_type status;

   rmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rmv_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[src/rmv_chk.sv]
// Port-level checker for the running statistics block, bound to the top level.
module rmv_chk
   import rmv_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   // A waiting result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in progress");

   // With at most one sample since clear there is no spread.
   a_no_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[191:160] == 32'd0 || rsp_tdata[191:160] == 32'd1)
      |-> rsp_tdata[95:32] == 64'd0)
      else $error("nonzero variance with fewer than two samples");

   // Once a sample is included, the maximum is at least the minimum.
   a_extremes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[191:160] != 32'd0
      |-> $signed(rsp_tdata[127:96]) >= $signed(rsp_tdata[159:128]))
      else $error("maximum below minimum after a sample");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind running_mean_variance_minmax rmv_chk u_rmv_chk (.*);

[dv/running_mean_variance_minmax_tb.sv]
// Self-checking testbench for the running mean, variance and min/max block.
module running_mean_variance_minmax_tb;
   import rmv_pkg::*;

   localparam int ITEM_LATENCY = SAMPLE_WIDTH_DEF + 74;
   localparam int STALL_LIMIT  = 3000;

   typedef struct packed {
      logic [31:0] mean;
      logic [63:0] variance;
      logic [31:0] max_v;
      logic [31:0] min_v;
      logic [31:0] count;
      logic        new_max;
      logic        new_min;
      logic [31:0] kept;
   } stats_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TUSER_WIDTH-1:0] req_tuser  = '0;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       csr_wen    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   // Own copy of the block's configuration and statistics.
   longint      min_start_cfg = MIN_START_RST;
   longint      max_start_cfg = MAX_START_RST;
   longint      mean_acc      = 0;
   logic [63:0] dev_acc       = '0;
   logic [31:0] count_acc     = '0;
   longint      min_acc       = MIN_START_RST;
   longint      max_acc       = MAX_START_RST;
   logic        new_max_acc   = 1'b0;
   logic        new_min_acc   = 1'b0;
   logic [31:0] kept_acc      = '0;

   stats_type pending_stats[$];
   int     send_idle_pct   = 0;
   int     recv_idle_pct   = 0;
   int     errors          = 0;
   int     items_sent      = 0;
   int     results_checked = 0;
   int     csr_writes      = 0;
   int     sum_saturations = 0;
   int     stall_cycles    = 0;

   always #5 clock = ~clock;

   running_mean_variance_minmax DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic logic [63:0] magnitude(longint d);
      if (d < 0) return 64'(-d);
      return 64'(d);
   endfunction

   // Folds one item into the statistics and returns the result it should report.
   function automatic stats_type fold_item(op_type op, logic [31:0] raw);
      longint      x;
      longint      prev;
      longint      div_n;
      logic [63:0] prod;
      stats_type   s;
      x = longint'($signed(raw));
      if (op == OP_STORE) kept_acc = raw;
      if (op == OP_INCLUDE || op == OP_STORE) begin
         prev = mean_acc;
         if (count_acc != '1) count_acc = count_acc + 1;
         div_n = longint'({32'd0, count_acc});
         mean_acc = prev + (x - prev) / div_n;
         // Both deviations share a sign, so the product is never negative.
         prod = magnitude(x - mean_acc) * magnitude(x - prev);
         if (prod > SUM_LIMIT - dev_acc) begin
            dev_acc = SUM_LIMIT;
            sum_saturations++;
         end else begin
            dev_acc = dev_acc + prod;
         end
         new_max_acc = x > max_acc;
         new_min_acc = x < min_acc;
         if (new_max_acc) max_acc = x;
         if (new_min_acc) min_acc = x;
      end else if (op == OP_CLEAR) begin
         // The mean, the flags and the kept sample survive a clear.
         min_acc   = min_start_cfg;
         max_acc   = max_start_cfg;
         dev_acc   = '0;
         count_acc = '0;
      end
      s.mean     = mean_acc[31:0];
      s.variance = dev_acc / ((count_acc != 0) ? {32'd0, count_acc} : 64'd1);
      s.max_v    = max_acc[31:0];
      s.min_v    = min_acc[31:0];
      s.count    = count_acc;
      s.new_max  = new_max_acc;
      s.new_min  = new_min_acc;
      s.kept     = kept_acc;
      return s;
   endfunction

   task automatic send_item(op_type op, logic [31:0] sample);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      // Now and then a long gap, so that idling lands on every phase of the work.
      if (send_idle_pct != 0 && $urandom_range(19) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(20, 140)) @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= sample;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_stats.push_back(fold_item(op, sample));
      items_sent++;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_results();
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   task automatic write_start_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      drain_results();
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_MIN_START) min_start_cfg = longint'($signed(value));
      else max_start_cfg = longint'($signed(value));
      csr_writes++;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [31:0] random_sample();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(200)) - 100);
         3: return 32'($signed($urandom_range(200000)) - 100000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_start();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return MIN_START_RST;
         3: return MAX_START_RST;
         4: return 32'($signed($urandom_range(2000)) - 1000);
         default: return $urandom();
      endcase
   endfunction

   // Mostly sample runs; clears break them up and the unused command is noise.
   function automatic op_type random_op();
      int r;
      r = $urandom_range(99);
      if (r < 4) return OP_CLEAR;
      if (r < 7) return OP_NONE;
      if (r < 40) return OP_STORE;
      return OP_INCLUDE;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      stats_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stats.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = pending_stats.pop_front();
            check_field("mean_value", 64'(want.mean), 64'(rsp_tdata[31:0]));
            check_field("variance", want.variance, rsp_tdata[95:32]);
            check_field("max_value", 64'(want.max_v), 64'(rsp_tdata[127:96]));
            check_field("min_value", 64'(want.min_v), 64'(rsp_tdata[159:128]));
            check_field("sample_count", 64'(want.count), 64'(rsp_tdata[191:160]));
            check_field("is_new_max", 64'(want.new_max), 64'(rsp_tdata[192]));
            check_field("is_new_min", 64'(want.new_min), 64'(rsp_tdata[193]));
            check_field("kept_sample", 64'(want.kept), 64'(rsp_tdata[225:194]));
            check_field("padding", '0, 64'(rsp_tdata[231:226]));
            results_checked++;
         end
      end
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Reset values, sample extremes, every command, and what a clear keeps.
   task automatic test_reset_state();
      send_item(OP_NONE, 32'h0);
      send_item(OP_INCLUDE, 32'h0);
      send_item(OP_INCLUDE, 32'h7FFF_FFFF);
      send_item(OP_INCLUDE, 32'h8000_0000);
      send_item(OP_STORE, 32'd12345);
      send_item(OP_STORE, 32'hFFFF_FFFF);
      send_item(OP_NONE, 32'hA5A5_A5A5);
      send_item(OP_CLEAR, 32'h5A5A_5A5A);
      send_item(OP_INCLUDE, 32'hFFFF_FF9C);
      send_item(OP_INCLUDE, 32'hFFFF_FF9C);
      drain_results();
   endtask

   // Alternating full-scale samples drive the deviation sum into its ceiling.
   task automatic test_sum_saturation();
      send_item(OP_CLEAR, 32'h0);
      repeat (4) begin
         send_item(OP_INCLUDE, 32'h8000_0000);
         send_item(OP_STORE, 32'h7FFF_FFFF);
      end
      send_item(OP_NONE, 32'h0);
      drain_results();
   endtask

   // New start values take effect only at the next clear.
   task automatic test_start_registers();
      write_start_reg(CSR_MIN_START, 32'h8000_0000);
      write_start_reg(CSR_MAX_START, 32'h7FFF_FFFF);
      send_item(OP_INCLUDE, 32'd5);
      send_item(OP_CLEAR, 32'h0);
      send_item(OP_INCLUDE, 32'h8000_0000);
      send_item(OP_INCLUDE, 32'h7FFF_FFFF);
      write_start_reg(CSR_MIN_START, 32'h7FFF_FFFF);
      write_start_reg(CSR_MAX_START, 32'h8000_0000);
      send_item(OP_CLEAR, 32'h0);
      send_item(OP_INCLUDE, 32'hFFFF_FFFD);
      drain_results();
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
      int left;
      int chunk;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      left = n_items;
      while (left > 0) begin
         chunk = $urandom_range(60, 140);
         if (chunk > left) chunk = left;
         repeat (chunk) send_item(random_op(), random_sample());
         left -= chunk;
         write_start_reg(CSR_MIN_START, random_start());
         write_start_reg(CSR_MAX_START, random_start());
         if ($urandom_range(1) == 1) send_item(OP_CLEAR, $urandom());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_sum_saturation();
      test_start_registers();
      test_random_traffic(30, 87, 517);
      test_random_traffic(87, 30, 517);
      test_random_traffic(0, 0, 516);
      drain_results();
      repeat (ITEM_LATENCY) @(posedge clock);
      $display("Sent %0d items, checked %0d results, made %0d start-value writes.",
               items_sent, results_checked, csr_writes);
      $display("Deviation sum hit its ceiling on %0d items across three idling mixes.",
               sum_saturations);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[running_mean_variance_minmax.f]
src/rmv_pkg.sv
src/rmv_div.sv
src/rmv_dp.sv
src/rmv_ctrl.sv
src/running_mean_variance_minmax.sv
src/rmv_chk.sv
dv/running_mean_variance_minmax_tb.sv
